// ===== rtl/nsqm_pkg.sv =====
// shared codes and types for the stack and queue manager
`timescale 1ns / 1ps
`default_nettype none

package nsqm_pkg;

  // command codes; the fourth code behaves as pop
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_PUSH   = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_POP_DATA
  } fsm_t;

  // input and output transfer widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

endpackage

`default_nettype wire

// ===== rtl/nsqm_ring_add.sv =====
// shared ring position adder with wrap at the list depth
`timescale 1ns / 1ps
`default_nettype none

module nsqm_ring_add #(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic [$clog2(LIST_DEPTH)-1:0] pos,
  input  wire logic [$clog2(LIST_DEPTH)-1:0] step,
  output logic      [$clog2(LIST_DEPTH)-1:0] sum
);

  localparam int POS_W = $clog2(LIST_DEPTH);
  localparam logic [POS_W:0] DEPTH_V = (POS_W + 1)'(LIST_DEPTH);

  logic [POS_W:0] raw;
  logic [POS_W:0] wrapped;

  always_comb begin
    raw = {1'b0, pos} + {1'b0, step};
    if (raw >= DEPTH_V) begin
      wrapped = raw - DEPTH_V;
    end else begin
      wrapped = raw;
    end
    sum = wrapped[POS_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/named_stack_queue_manager.sv =====
// top level of the multi-list stack and queue manager
//
// channel  dir  fields (low bit up)
// s_*      in   command[1:0] list_id[5:2] make_stack[6] push_value[38:7] zero[39]
// m_*      out  status[2:0] popped_value[34:3] value_valid[35] zero[39:36]
//
// create, push and any error answer from S_LOOKUP, a good pop from S_POP_DATA:
// the slot record memory is read as the command is taken, S_LOOKUP does the
// ring adder and entry memory access, S_POP_DATA the registered entry read.
// one command is worked on at a time; s_tready is high only while idle.
// a finished result waits in the output register; the next command is still
// taken, and its result stage holds until the output register frees up.
// reset clears the slot in-use bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module named_stack_queue_manager #(
  parameter int NUM_LISTS  = 16,
  parameter int LIST_DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command[1:0], list_id[5:2], make_stack[6], push_value[38:7], zero[39]
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], popped_value[34:3], value_valid[35], zero[39:36]
  output logic [39:0]      m_tdata
);

  localparam int SLOT_W   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int ID_EXT   = (SLOT_W > 4) ? SLOT_W : 4;
  localparam int POS_W    = $clog2(LIST_DEPTH);
  localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
  localparam int ENT_DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W   = $clog2(ENT_DEPTH);
  localparam int STORE_W  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic [8:0]       NUM_LISTS_V = 9'(NUM_LISTS);
  localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(LIST_DEPTH);
  localparam logic [POS_W-1:0] STEP_BACK   = POS_W'(LIST_DEPTH - 1);
  localparam logic [POS_W-1:0] STEP_ONE    = POS_W'(1);

  typedef struct packed {
    logic             is_stack;
    logic [POS_W-1:0] front;
    logic [CNT_W-1:0] count;
  } slot_rec_t;

  // input unpacking
  logic [1:0]  in_command;
  logic [3:0]  in_list_id;
  logic        in_make_stack;
  logic [31:0] in_push_value;
  logic [ID_EXT-1:0] in_id_ext;
  logic [SLOT_W-1:0] in_slot;

  assign in_command    = s_tdata[1:0];
  assign in_list_id    = s_tdata[5:2];
  assign in_make_stack = s_tdata[6];
  assign in_push_value = s_tdata[38:7];
  assign in_id_ext     = ID_EXT'(in_list_id);
  assign in_slot       = in_id_ext[SLOT_W-1:0];

  nsqm_pkg::fsm_t state, state_next;

  // command held while it is worked on
  logic [1:0]         cmd;
  logic               id_ok;
  logic [SLOT_W-1:0]  slot;
  logic [ADDR_W-1:0]  base;
  logic               mk_stack;
  logic [STORE_W-1:0] word;

  logic [NUM_LISTS-1:0] in_use;

  // slot record memory
  slot_rec_t slot_mem [NUM_LISTS];
  slot_rec_t rec;
  logic      slot_re;
  logic      slot_we;
  slot_rec_t slot_wdata;

  // entry memory
  logic [STORE_W-1:0] ent_mem [ENT_DEPTH];
  logic [STORE_W-1:0] ent_rd;
  logic               ent_we;
  logic               ent_re;
  logic [ADDR_W-1:0]  ent_addr;

  // output register
  nsqm_pkg::status_t out_status, res_status;
  logic [31:0]       out_value;
  logic              out_vv;
  logic              load_out;
  logic [31:0]       res_value;
  logic              res_vv;

  logic             accept;
  logic             out_free;
  logic             slot_used;
  logic             set_used;
  logic [POS_W-1:0] ring_step;
  logic [POS_W-1:0] ring_sum;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == nsqm_pkg::S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign slot_re  = accept;
  assign slot_used = id_ok && in_use[slot];

  nsqm_ring_add #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ring (
    .pos (rec.front),
    .step(ring_step),
    .sum (ring_sum)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= in_command;
      id_ok    <= ({5'd0, in_list_id} < NUM_LISTS_V);
      slot     <= in_slot;
      base     <= ADDR_W'(in_slot) * ADDR_W'(LIST_DEPTH);
      mk_stack <= in_make_stack;
      word     <= in_push_value[STORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot] <= slot_wdata;
    end
    if (slot_re) begin
      rec <= slot_mem[in_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= word;
    end
    if (ent_re) begin
      ent_rd <= ent_mem[ent_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (set_used) begin
      in_use[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsqm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    slot_we    = 1'b0;
    slot_wdata = rec;
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    ent_addr   = base + ADDR_W'(rec.front);
    set_used   = 1'b0;
    load_out   = 1'b0;
    res_status = nsqm_pkg::ST_OK;
    res_value  = '0;
    res_vv     = 1'b0;
    ring_step  = STEP_ONE;

    unique case (state)
      nsqm_pkg::S_IDLE: begin
        if (accept) begin
          state_next = nsqm_pkg::S_LOOKUP;
        end
      end

      nsqm_pkg::S_LOOKUP: begin
        case (cmd)
          nsqm_pkg::CMD_CREATE: begin
            ring_step = STEP_ONE;
          end
          nsqm_pkg::CMD_PUSH: begin
            ring_step = rec.is_stack ? STEP_BACK : rec.count[POS_W-1:0];
          end
          default: begin
            ring_step = STEP_ONE;
          end
        endcase

        if (out_free) begin
          state_next = nsqm_pkg::S_IDLE;
          load_out   = 1'b1;
          case (cmd)
            nsqm_pkg::CMD_CREATE: begin
              if (!id_ok) begin
                res_status = nsqm_pkg::ST_MISSING;
              end else if (in_use[slot]) begin
                res_status = nsqm_pkg::ST_EXISTS;
              end else begin
                set_used   = 1'b1;
                slot_we    = 1'b1;
                slot_wdata = '{is_stack: mk_stack, front: '0, count: '0};
              end
            end
            nsqm_pkg::CMD_PUSH: begin
              if (!slot_used) begin
                res_status = nsqm_pkg::ST_MISSING;
              end else if (rec.count == DEPTH_CNT) begin
                res_status = nsqm_pkg::ST_FULL;
              end else begin
                // stack: new front one back; queue: rear past the last entry
                ent_we   = 1'b1;
                ent_addr = base + ADDR_W'(ring_sum);
                slot_we  = 1'b1;
                slot_wdata.count = rec.count + CNT_W'(1);
                if (rec.is_stack) begin
                  slot_wdata.front = ring_sum;
                end
              end
            end
            default: begin
              if (!slot_used) begin
                res_status = nsqm_pkg::ST_MISSING;
              end else if (rec.count == '0) begin
                res_status = nsqm_pkg::ST_EMPTY;
              end else begin
                load_out   = 1'b0;
                state_next = nsqm_pkg::S_POP_DATA;
                ent_re     = 1'b1;
                slot_we    = 1'b1;
                slot_wdata.front = ring_sum;
                slot_wdata.count = rec.count - CNT_W'(1);
              end
            end
          endcase
        end
      end

      nsqm_pkg::S_POP_DATA: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_value  = 32'(ent_rd);
          res_vv     = 1'b1;
          state_next = nsqm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = nsqm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_vv     <= res_vv;
    end
  end

  assign m_tdata = {4'd0, out_vv, out_value, out_status};

  // a popped word only ever comes with a good status
  a_vv_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_vv |-> out_status == nsqm_pkg::ST_OK)
    else $error("popped word with error status");

  // an accepted command goes straight to the slot lookup
  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == nsqm_pkg::S_LOOKUP)
    else $error("accepted command did not reach lookup");

  // the entry memory never writes and reads in one cycle
  a_ent_port: assert property (@(posedge clk) disable iff (rst)
    !(ent_we && ent_re))
    else $error("entry memory write and read together");

  // a live slot never holds more than the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == nsqm_pkg::S_LOOKUP && slot_used |-> rec.count <= DEPTH_CNT)
    else $error("slot count beyond list depth");

endmodule

`default_nettype wire
